/* rtl/core/assert_macros.svh */
// Assertion macros shared by the keyed slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define KST_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("keyed slot table assertion failed");

// Check that pre is followed by post in the next cycle.
`define KST_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("keyed slot table assertion failed");

`endif

/* rtl/core/kst_pkg.sv */
// Package: beat types, operation codes and compare result struct for the slot table.
package kst_pkg;

   localparam logic [2:0] KIND_INSERT   = 3'd0;
   localparam logic [2:0] KIND_REMOVE   = 3'd1;
   localparam logic [2:0] KIND_LOOKUP   = 3'd2;
   localparam logic [2:0] KIND_POSITION = 3'd3;
   localparam logic [2:0] KIND_UPDATE   = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] key;
      logic [63:0] payload;
      logic [5:0]  position;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] out_key;
      logic [63:0] out_payload;
      logic [5:0]  count;
      logic        full_res;
      logic        empty_res;
   } rsp_type;

   typedef struct packed {
      logic key_hit;
      logic free_hit;
      logic rank_hit;
   } hit_type;

endpackage

/* rtl/core/keyed_slot_table.sv */
// Top level: keyed slot table with a sequencer scanning slot memory through one compare unit.
//
// A table of SLOTS entries (valid flag, key, payload) in on-chip memory, scanned one
// slot per cycle through a single compare unit. After reset a clearing pass zeroes
// the valid flags; req_ready stays low during it. One request is in work at a time:
// accept, then a scan (one read per slot, data compared in the next cycle), an extra
// write step for an update that moves its entry to a lower free slot, and a step to
// load the result register. Lookups, removes and updates stop at the matching slot and
// lookup by position at the wanted rank; inserts scan the whole table unless the key is
// already present, where they stop at it. Requests that fail at once (full table, bad
// position, unknown kind) skip the scan. A new request is taken while the previous
// result still waits on rsp_ready.
`include "assert_macros.svh"

module keyed_slot_table #(
   parameter int SLOTS        = 32,
   parameter int KEY_BITS     = 64,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kst_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_WRITE2 = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // request and working registers
   logic [2:0]              kind_ff, kind_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [5:0]              pos_ff, pos_in;
   logic [IDX_W-1:0]        eval_ff, eval_in;
   logic [CNT_W-1:0]        seen_ff, seen_in;
   logic                    free_fnd_ff, free_fnd_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]        match_idx_ff, match_idx_in;
   logic                    res_ok_ff, res_ok_in;
   logic [KEY_BITS-1:0]     res_key_ff, res_key_in;
   logic [PAYLOAD_BITS-1:0] res_pay_ff, res_pay_in;
   kst_pkg::rsp_type        rsp_ff, rsp_in;

   // memory and compare unit
   logic [IDX_W-1:0]        rd_addr;
   logic                    rd_vld;
   logic [KEY_BITS-1:0]     rd_key;
   logic [PAYLOAD_BITS-1:0] rd_payload;
   logic                    vwr_en;
   logic [IDX_W-1:0]        vwr_addr;
   logic                    vwr_bit;
   logic                    ewr_en;
   logic [IDX_W-1:0]        ewr_addr;
   kst_pkg::hit_type        hit;

   logic [IDX_W-1:0]        free_sel;
   logic                    last_slot;
   logic [CNT_W+5:0]        pos_ext;
   logic [CNT_W+5:0]        cnt_ext;
   logic [KEY_BITS+63:0]    okey_ext;
   logic [PAYLOAD_BITS+63:0] opay_ext;

   kst_mem #(
      .SLOTS        (SLOTS),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IDX_W        (IDX_W)
   ) u_mem (
      .clock       (clock),
      .rd_addr     (rd_addr),
      .rd_vld      (rd_vld),
      .rd_key      (rd_key),
      .rd_payload  (rd_payload),
      .vwr_en      (vwr_en),
      .vwr_addr    (vwr_addr),
      .vwr_bit     (vwr_bit),
      .ewr_en      (ewr_en),
      .ewr_addr    (ewr_addr),
      .ewr_key     (key_ff),
      .ewr_payload (pay_ff)
   );

   kst_match #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W)
   ) u_match (
      .rd_vld   (rd_vld),
      .rd_key   (rd_key),
      .req_key  (key_ff),
      .seen     (seen_ff),
      .position (pos_ff),
      .hit      (hit)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      pos_in       = pos_ff;
      eval_in      = eval_ff;
      seen_in      = seen_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      match_idx_in = match_idx_ff;
      res_ok_in    = res_ok_ff;
      res_key_in   = res_key_ff;
      res_pay_in   = res_pay_ff;
      rsp_in       = rsp_ff;

      rd_addr  = scan_ff[IDX_W-1:0];
      vwr_en   = 1'b0;
      vwr_addr = eval_ff;
      vwr_bit  = 1'b0;
      ewr_en   = 1'b0;
      ewr_addr = eval_ff;

      // lowest free slot seen so far, or the slot under compare
      free_sel  = free_fnd_ff ? free_idx_ff : eval_ff;
      last_slot = (eval_ff == IDX_W'(SLOTS - 1));
      pos_ext   = {{CNT_W{1'b0}}, req_data.position};
      cnt_ext   = {6'd0, count_ff};
      okey_ext  = {64'd0, res_key_ff};
      opay_ext  = {64'd0, res_pay_ff};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            vwr_en   = 1'b1;
            vwr_addr = clr_ff;
            vwr_bit  = 1'b0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in     = req_data.kind;
               key_in      = req_data.key[KEY_BITS-1:0];
               pay_in      = req_data.payload[PAYLOAD_BITS-1:0];
               pos_in      = req_data.position;
               res_ok_in   = 1'b0;
               res_key_in  = '0;
               res_pay_in  = '0;
               scan_in     = '0;
               pend_in     = 1'b0;
               seen_in     = '0;
               free_fnd_in = 1'b0;
               unique case (req_data.kind)
                  kst_pkg::KIND_INSERT: begin
                     state_in = (count_ff == CNT_W'(SLOTS)) ? ST_RESP : ST_SCAN;
                  end
                  kst_pkg::KIND_REMOVE, kst_pkg::KIND_LOOKUP, kst_pkg::KIND_UPDATE: begin
                     state_in = ST_SCAN;
                  end
                  kst_pkg::KIND_POSITION: begin
                     state_in = ((pos_ext != '0) && (pos_ext <= cnt_ext)) ? ST_SCAN
                                                                           : ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue the next read while the previous slot is compared
            if (scan_ff < CNT_W'(SLOTS)) begin
               pend_in = 1'b1;
               eval_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end

            if (pend_ff) begin
               if (hit.free_hit && !free_fnd_ff) begin
                  free_fnd_in = 1'b1;
                  free_idx_in = eval_ff;
               end

               if (kind_ff == kst_pkg::KIND_POSITION) begin
                  if (hit.rank_hit) begin
                     res_ok_in  = 1'b1;
                     res_key_in = rd_key;
                     res_pay_in = rd_payload;
                     state_in   = ST_RESP;
                  end
                  if (rd_vld) begin
                     seen_in = seen_ff + 1'b1;
                  end
               end else if (hit.key_hit) begin
                  state_in = ST_RESP;
                  unique case (kind_ff)
                     kst_pkg::KIND_LOOKUP: begin
                        res_ok_in  = 1'b1;
                        res_key_in = rd_key;
                        res_pay_in = rd_payload;
                     end
                     kst_pkg::KIND_REMOVE: begin
                        res_ok_in  = 1'b1;
                        res_key_in = rd_key;
                        res_pay_in = rd_payload;
                        vwr_en     = 1'b1;
                        vwr_addr   = eval_ff;
                        vwr_bit    = 1'b0;
                        count_in   = count_ff - 1'b1;
                     end
                     kst_pkg::KIND_UPDATE: begin
                        res_ok_in    = 1'b1;
                        res_key_in   = rd_key;
                        res_pay_in   = rd_payload;
                        vwr_en       = 1'b1;
                        vwr_addr     = free_sel;
                        vwr_bit      = 1'b1;
                        ewr_en       = 1'b1;
                        ewr_addr     = free_sel;
                        match_idx_in = eval_ff;
                        // entry moves down: drop the old slot next cycle
                        if (free_fnd_ff) begin
                           state_in = ST_WRITE2;
                        end
                     end
                     default: begin
                        // insert of a present key fails
                        res_ok_in = 1'b0;
                     end
                  endcase
               end else if (last_slot) begin
                  state_in = ST_RESP;
                  if (kind_ff == kst_pkg::KIND_INSERT) begin
                     res_ok_in = 1'b1;
                     vwr_en    = 1'b1;
                     vwr_addr  = free_sel;
                     vwr_bit   = 1'b1;
                     ewr_en    = 1'b1;
                     ewr_addr  = free_sel;
                     count_in  = count_ff + 1'b1;
                  end
               end
            end
         end
         ST_WRITE2: begin
            vwr_en   = 1'b1;
            vwr_addr = match_idx_ff;
            vwr_bit  = 1'b0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = res_ok_ff;
               rsp_in.out_key     = okey_ext[63:0];
               rsp_in.out_payload = opay_ext[63:0];
               rsp_in.count       = cnt_ext[5:0];
               rsp_in.full_res    = (count_ff == CNT_W'(SLOTS));
               rsp_in.empty_res   = (count_ff == '0);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      pay_ff       <= pay_in;
      pos_ff       <= pos_in;
      eval_ff      <= eval_in;
      seen_ff      <= seen_in;
      free_fnd_ff  <= free_fnd_in;
      free_idx_ff  <= free_idx_in;
      match_idx_ff <= match_idx_in;
      res_ok_ff    <= res_ok_in;
      res_key_ff   <= res_key_in;
      res_pay_ff   <= res_pay_in;
      rsp_ff       <= rsp_in;
   end

   `KST_ASSERT_NEXT(a_count_scan_only, state_ff != ST_SCAN, $stable(count_ff))
   `KST_ASSERT(a_rsp_from_resp, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
   `KST_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, !req_ready)
   `KST_ASSERT(a_write2_update, (state_ff == ST_WRITE2) |-> (kind_ff == kst_pkg::KIND_UPDATE))

endmodule

/* rtl/core/kst_mem.sv */
// Slot storage: valid flag memory and key/payload memory, registered reads.
module kst_mem #(
   parameter int SLOTS        = 32,
   parameter int KEY_BITS     = 64,
   parameter int PAYLOAD_BITS = 64,
   parameter int IDX_W        = 5
) (
   input  logic                    clock,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic                    rd_vld,
   output logic [KEY_BITS-1:0]     rd_key,
   output logic [PAYLOAD_BITS-1:0] rd_payload,
   input  logic                    vwr_en,
   input  logic [IDX_W-1:0]        vwr_addr,
   input  logic                    vwr_bit,
   input  logic                    ewr_en,
   input  logic [IDX_W-1:0]        ewr_addr,
   input  logic [KEY_BITS-1:0]     ewr_key,
   input  logic [PAYLOAD_BITS-1:0] ewr_payload
);

   logic                             valid_mem [SLOTS];
   logic [KEY_BITS+PAYLOAD_BITS-1:0] entry_mem [SLOTS];
   logic [KEY_BITS+PAYLOAD_BITS-1:0] entry_rd_ff;

   always_ff @(posedge clock) begin
      if (vwr_en) begin
         valid_mem[vwr_addr] <= vwr_bit;
      end
      rd_vld <= valid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ewr_en) begin
         entry_mem[ewr_addr] <= {ewr_key, ewr_payload};
      end
      entry_rd_ff <= entry_mem[rd_addr];
   end

   assign rd_key     = entry_rd_ff[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS];
   assign rd_payload = entry_rd_ff[PAYLOAD_BITS-1:0];

endmodule

/* rtl/core/kst_match.sv */
// Shared slot compare unit: key match, free slot and rank match for one slot word.
module kst_match #(
   parameter int KEY_BITS = 64,
   parameter int CNT_W    = 6
) (
   input  logic                rd_vld,
   input  logic [KEY_BITS-1:0] rd_key,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic [CNT_W-1:0]    seen,
   input  logic [5:0]          position,
   output kst_pkg::hit_type    hit
);

   logic [CNT_W+5:0] seen_inc;
   logic [CNT_W+5:0] pos_ext;

   always_comb begin
      seen_inc     = {6'd0, seen} + 1'b1;
      pos_ext      = {{CNT_W{1'b0}}, position};
      hit.key_hit  = rd_vld && (rd_key == req_key);
      hit.free_hit = !rd_vld;
      // this slot is the wanted one when it is valid and lifts the tally to the rank
      hit.rank_hit = rd_vld && (seen_inc == pos_ext);
   end

endmodule

/* tb/sv/keyed_slot_table_tb.sv */
// Testbench for keyed_slot_table: queued request driver, result monitor and table predictor.
`timescale 1ns / 100ps

module keyed_slot_table_tb;

   localparam int SLOTS       = 32;
   localparam int RANDOM_REQS = 1550;
   localparam int KEY_POOL    = 40;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 64;

   // kinds the block must ignore
   localparam logic [2:0] KIND_SPARE_A = 3'd5;
   localparam logic [2:0] KIND_SPARE_B = 3'd6;
   localparam logic [2:0] KIND_SPARE_C = 3'd7;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   kst_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   kst_pkg::rsp_type rsp_data;

   keyed_slot_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // shadow copy of the table
   logic        tab_valid [SLOTS];
   logic [63:0] tab_key [SLOTS];
   logic [63:0] tab_payload [SLOTS];
   int          tab_count = 0;

   kst_pkg::req_type pending_req [$];
   kst_pkg::rsp_type expected_rsp [$];
   logic [63:0]      key_pool [KEY_POOL];

   int accepted_reqs = 0;
   int matched_rsps  = 0;
   int mismatches    = 0;
   int cycle_count   = 0;
   int kind_seen [8];
   int ok_seen       = 0;
   int full_seen     = 0;
   int empty_seen    = 0;
   kst_pkg::rsp_type want;
   logic             bad;

   initial begin
      for (int s = 0; s < SLOTS; s++) tab_valid[s] = 1'b0;
      for (int k = 0; k < 8; k++) kind_seen[k] = 0;
   end

   function automatic int find_slot(logic [63:0] key);
      int hit;
      hit = -1;
      for (int s = 0; s < SLOTS; s++)
         if (hit < 0 && tab_valid[s] && tab_key[s] == key) hit = s;
      return hit;
   endfunction

   function automatic int lowest_free();
      int hit;
      hit = -1;
      for (int s = 0; s < SLOTS; s++)
         if (hit < 0 && !tab_valid[s]) hit = s;
      return hit;
   endfunction

   // apply one request to the shadow table and return the result it should produce
   function automatic kst_pkg::rsp_type apply_request(kst_pkg::req_type r);
      kst_pkg::rsp_type res;
      int               s;
      int               seen;
      res = '0;
      case (r.kind)
         kst_pkg::KIND_INSERT: begin
            if (tab_count < SLOTS && find_slot(r.key) < 0) begin
               s = lowest_free();
               tab_valid[s]   = 1'b1;
               tab_key[s]     = r.key;
               tab_payload[s] = r.payload;
               tab_count++;
               res.ok = 1'b1;
            end
         end
         kst_pkg::KIND_REMOVE, kst_pkg::KIND_LOOKUP, kst_pkg::KIND_UPDATE: begin
            s = find_slot(r.key);
            if (s >= 0) begin
               res.ok          = 1'b1;
               res.out_key     = tab_key[s];
               res.out_payload = tab_payload[s];
               if (r.kind != kst_pkg::KIND_LOOKUP) begin
                  tab_valid[s] = 1'b0;
                  tab_count--;
               end
               if (r.kind == kst_pkg::KIND_UPDATE) begin
                  s = lowest_free();
                  tab_valid[s]   = 1'b1;
                  tab_key[s]     = r.key;
                  tab_payload[s] = r.payload;
                  tab_count++;
               end
            end
         end
         kst_pkg::KIND_POSITION: begin
            if (r.position != 0 && r.position <= tab_count) begin
               seen = 0;
               for (int t = 0; t < SLOTS; t++) begin
                  if (tab_valid[t]) begin
                     seen++;
                     if (seen == r.position) begin
                        res.ok          = 1'b1;
                        res.out_key     = tab_key[t];
                        res.out_payload = tab_payload[t];
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      res.count     = tab_count[5:0];
      res.full_res  = (tab_count == SLOTS);
      res.empty_res = (tab_count == 0);
      kind_seen[r.kind]++;
      if (res.ok) ok_seen++;
      if (res.full_res) full_seen++;
      if (res.empty_res) empty_seen++;
      return res;
   endfunction

   // a quiet window of requests runs with no idling on either side
   function automatic logic take_break();
      if (accepted_reqs >= 500 && accepted_reqs < 800) return 1'b0;
      return $urandom_range(0, 99) < 11;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 99) < 8) return rand_word();
      return key_pool[$urandom_range(0, KEY_POOL - 1)];
   endfunction

   function automatic logic [63:0] pick_payload();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 10) return ALL_ONES;
      return rand_word();
   endfunction

   function automatic logic [5:0] pick_position();
      if ($urandom_range(0, 99) < 10) return 6'($urandom_range(0, 63));
      return 6'($urandom_range(0, SLOTS + 2));
   endfunction

   task automatic add_req(logic [2:0] kind, logic [63:0] key, logic [63:0] payload,
                          logic [5:0] position);
      kst_pkg::req_type r;
      r.kind     = kind;
      r.key      = key;
      r.payload  = payload;
      r.position = position;
      pending_req.push_back(r);
   endtask

   // driver: advance to the next beat once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(apply_request(req_data));
            accepted_reqs++;
         end
         if (!req_valid || req_ready) begin
            if (pending_req.size() != 0 && !take_break()) begin
               req_valid <= 1'b1;
               req_data  <= pending_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result beat ok=%0b key=%h payload=%h count=%0d",
                           rsp_data.ok, rsp_data.out_key, rsp_data.out_payload,
                           rsp_data.count);
            end else begin
               want = expected_rsp.pop_front();
               bad  = (rsp_data.ok !== want.ok) || (rsp_data.out_key !== want.out_key) ||
                      (rsp_data.out_payload !== want.out_payload) ||
                      (rsp_data.count !== want.count) ||
                      (rsp_data.full_res !== want.full_res) ||
                      (rsp_data.empty_res !== want.empty_res);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: result %0d mismatch", matched_rsps);
                     $display("  expected ok=%0b key=%h payload=%h count=%0d full=%0b empty=%0b",
                              want.ok, want.out_key, want.out_payload, want.count,
                              want.full_res, want.empty_res);
                     $display("  actual   ok=%0b key=%h payload=%h count=%0d full=%0b empty=%0b",
                              rsp_data.ok, rsp_data.out_key, rsp_data.out_payload,
                              rsp_data.count, rsp_data.full_res, rsp_data.empty_res);
                  end
               end
               matched_rsps++;
            end
         end
         rsp_ready <= !take_break();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout with %0d results outstanding", expected_rsp.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int          mode;
      int          roll;
      logic [63:0] key_a;
      logic [63:0] key_b;

      for (int k = 0; k < KEY_POOL; k++) key_pool[k] = rand_word();
      key_pool[0] = '0;
      key_pool[1] = ALL_ONES;
      key_a = key_pool[2];
      key_b = key_pool[3];

      // directed: empty table, extremes, duplicate, move on update, ignored kinds
      add_req(kst_pkg::KIND_LOOKUP, key_a, '0, '0);
      add_req(kst_pkg::KIND_POSITION, '0, '0, 6'd1);
      add_req(kst_pkg::KIND_REMOVE, key_a, '0, '0);
      add_req(kst_pkg::KIND_UPDATE, key_a, ALL_ONES, '0);
      add_req(kst_pkg::KIND_INSERT, '0, ALL_ONES, 6'h3F);
      add_req(kst_pkg::KIND_INSERT, ALL_ONES, '0, '0);
      add_req(kst_pkg::KIND_INSERT, '0, rand_word(), '0);
      add_req(kst_pkg::KIND_LOOKUP, '0, '0, '0);
      add_req(kst_pkg::KIND_LOOKUP, ALL_ONES, ALL_ONES, '0);
      add_req(kst_pkg::KIND_POSITION, ALL_ONES, ALL_ONES, 6'd0);
      add_req(kst_pkg::KIND_POSITION, '0, '0, 6'd2);
      add_req(kst_pkg::KIND_POSITION, '0, '0, 6'd3);
      add_req(kst_pkg::KIND_POSITION, '0, '0, 6'h3F);
      add_req(kst_pkg::KIND_INSERT, key_a, rand_word(), '0);
      add_req(kst_pkg::KIND_REMOVE, '0, '0, '0);
      add_req(kst_pkg::KIND_UPDATE, key_a, 64'h5555_5555_5555_5555, '0);
      add_req(kst_pkg::KIND_POSITION, '0, '0, 6'd1);
      add_req(kst_pkg::KIND_UPDATE, ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, '0);
      add_req(kst_pkg::KIND_LOOKUP, key_a, '0, '0);
      add_req(KIND_SPARE_A, key_a, rand_word(), 6'd1);
      add_req(KIND_SPARE_B, ALL_ONES, ALL_ONES, 6'h3F);
      add_req(KIND_SPARE_C, rand_word(), rand_word(), 6'($urandom_range(0, 63)));
      add_req(kst_pkg::KIND_INSERT, key_b, rand_word(), '0);
      add_req(kst_pkg::KIND_REMOVE, key_a, '0, '0);

      // random: phases lean toward filling, draining or a mix
      mode = 0;
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n != 0 && n % 100 == 0) mode = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         case (mode)
            0: begin
               if (roll < 60)
                  add_req(kst_pkg::KIND_INSERT, pick_key(), pick_payload(), '0);
               else if (roll < 70)
                  add_req(kst_pkg::KIND_UPDATE, pick_key(), pick_payload(), '0);
               else if (roll < 80)
                  add_req(kst_pkg::KIND_LOOKUP, pick_key(), '0, '0);
               else if (roll < 90)
                  add_req(kst_pkg::KIND_POSITION, '0, '0, pick_position());
               else if (roll < 97)
                  add_req(kst_pkg::KIND_REMOVE, pick_key(), '0, '0);
               else
                  add_req(3'($urandom_range(5, 7)), rand_word(), rand_word(), pick_position());
            end
            1: begin
               if (roll < 50)
                  add_req(kst_pkg::KIND_REMOVE, pick_key(), '0, '0);
               else if (roll < 62)
                  add_req(kst_pkg::KIND_INSERT, pick_key(), pick_payload(), '0);
               else if (roll < 74)
                  add_req(kst_pkg::KIND_LOOKUP, pick_key(), '0, '0);
               else if (roll < 82)
                  add_req(kst_pkg::KIND_UPDATE, pick_key(), pick_payload(), '0);
               else if (roll < 94)
                  add_req(kst_pkg::KIND_POSITION, '0, '0, pick_position());
               else
                  add_req(3'($urandom_range(5, 7)), rand_word(), rand_word(), pick_position());
            end
            default: begin
               if (roll < 19)
                  add_req(kst_pkg::KIND_INSERT, pick_key(), pick_payload(), '0);
               else if (roll < 38)
                  add_req(kst_pkg::KIND_REMOVE, pick_key(), '0, '0);
               else if (roll < 57)
                  add_req(kst_pkg::KIND_LOOKUP, pick_key(), pick_payload(), '0);
               else if (roll < 76)
                  add_req(kst_pkg::KIND_POSITION, pick_key(), '0, pick_position());
               else if (roll < 95)
                  add_req(kst_pkg::KIND_UPDATE, pick_key(), pick_payload(), '0);
               else
                  add_req(3'($urandom_range(5, 7)), rand_word(), rand_word(), pick_position());
            end
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d requests: %0d insert, %0d remove, %0d lookup, %0d rank,",
               accepted_reqs, kind_seen[kst_pkg::KIND_INSERT], kind_seen[kst_pkg::KIND_REMOVE],
               kind_seen[kst_pkg::KIND_LOOKUP], kind_seen[kst_pkg::KIND_POSITION]);
      $display("  %0d update, %0d ignored", kind_seen[kst_pkg::KIND_UPDATE],
               kind_seen[KIND_SPARE_A] + kind_seen[KIND_SPARE_B] + kind_seen[KIND_SPARE_C]);
      $display("%0d succeeded; table seen full %0d times and empty %0d times; %0d mismatches",
               ok_seen, full_seen, empty_seen, mismatches);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/kst_mem.sv
rtl/core/kst_match.sv
rtl/core/keyed_slot_table.sv
tb/sv/keyed_slot_table_tb.sv
